// ===== design/pulse_wave_channel_assert.svh =====
// Assertion macros shared by the pulse wave channel modules.
`ifndef PULSE_WAVE_CHANNEL_ASSERT_SVH
`define PULSE_WAVE_CHANNEL_ASSERT_SVH

`ifndef SYNTHESIS
`define PWC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pulse wave channel check failed");
`define PWC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("pulse wave channel check failed");
`else
`define PWC_ASSERT(label, prop)
`define PWC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== design/pwc_pkg.sv =====
// Shared types, codes and tables for the pulse wave channel.
package pwc_pkg;

  typedef enum logic [1:0] {
    CmdTimer   = 2'd0,
    CmdQuarter = 2'd1,
    CmdHalf    = 2'd2,
    CmdWrite   = 2'd3
  } cmd_e;

  localparam logic [2:0] RegDuty     = 3'd0;
  localparam logic [2:0] RegSweep    = 3'd1;
  localparam logic [2:0] RegPeriodLo = 3'd2;
  localparam logic [2:0] RegPeriodHi = 3'd3;
  localparam logic [2:0] RegEnable   = 3'd4;

  localparam logic [4:0] SweepIdle = 5'h1F;

  localparam logic [7:0] DutyTable [4] = '{8'h80, 8'hC0, 8'hF0, 8'h3F};

  localparam logic [7:0] LengthTable [32] = '{
    8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
    8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
    8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
    8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E
  };

  typedef struct packed {
    cmd_e       cmd;
    logic [2:0] reg_sel;
    logic [7:0] data;
    logic       late_length_write;
  } item_t;

  typedef struct packed {
    logic [3:0] sample;
    logic       length_active;
  } result_t;

endpackage

// ===== design/pulse_wave_channel.sv =====
// Pulse wave channel top level: input register, state update, result register.
//
//   channel | handshake            | beat contents
//   --------+----------------------+-------------------------------------------
//   in      | in_valid_i/in_ready_o| cmd_i, reg_sel_i, data_i, late_length_write_i
//   out     | out_valid_o/out_ready_i | sample_o, length_active_o
//
// One beat per cycle sustained unless out_ready_i stalls the result register.
// Latency is set by the input register and the result register around the state update.
// Reset clears all channel state and both valid flags.
// A stalled result register holds one beat; the input register takes one more behind it.
`include "pulse_wave_channel_assert.svh"

module pulse_wave_channel (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [2:0] reg_sel_i,
  input  logic [7:0] data_i,
  input  logic       late_length_write_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] sample_o,
  output logic       length_active_o
);
  import pwc_pkg::*;

  logic    in_valid_q, in_valid_d;
  item_t   item_q;
  logic    out_valid_q, out_valid_d;
  result_t result_q;
  result_t result_next;
  logic    advance;
  logic    take_in;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign take_in    = in_valid_i && in_ready_o;

  assign in_valid_d  = take_in ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  pwc_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .result_o (result_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      item_q.cmd               <= cmd_e'(cmd_i);
      item_q.reg_sel           <= reg_sel_i;
      item_q.data              <= data_i;
      item_q.late_length_write <= late_length_write_i;
    end
    if (advance) begin
      result_q <= result_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_o        = result_q.sample;
  assign length_active_o = result_q.length_active;

  `PWC_ASSERT(a_advance_fills_out, advance |=> out_valid_q)
  `PWC_ASSERT(a_no_overrun, (take_in && in_valid_q) |-> (!out_valid_q || out_ready_i))
  `PWC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!in_valid_q && !out_valid_q))

endmodule

// ===== design/pwc_state.sv =====
// Channel state registers and the single-pass update for one beat.
`include "pulse_wave_channel_assert.svh"

module pwc_state (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  pwc_pkg::item_t   item_i,
  output pwc_pkg::result_t result_o
);
  import pwc_pkg::*;

  logic [1:0]  duty_mode_q, duty_mode_d;
  logic        halt_flag_q, halt_flag_d;
  logic        const_volume_q, const_volume_d;
  logic [3:0]  volume_period_q, volume_period_d;
  logic        sweep_on_q, sweep_on_d;
  logic [2:0]  sweep_period_q, sweep_period_d;
  logic        sweep_down_q, sweep_down_d;
  logic [2:0]  sweep_shift_q, sweep_shift_d;
  logic [10:0] tone_period_q, tone_period_d;
  logic [11:0] period_count_q, period_count_d;
  logic [2:0]  seq_step_q, seq_step_d;
  logic        length_enable_q, length_enable_d;
  logic [7:0]  length_count_q, length_count_d;
  logic        env_start_q, env_start_d;
  logic [4:0]  env_divider_q, env_divider_d;
  logic [3:0]  decay_level_q, decay_level_d;
  logic [4:0]  sweep_count_q, sweep_count_d;
  logic        sweep_reload_q, sweep_reload_d;
  logic        skip_load_q, skip_load_d;
  logic [3:0]  sample_hold_q, sample_hold_d;

  logic [11:0] sweep_target;
  logic [10:0] sweep_change;
  logic        freq_valid;
  logic [3:0]  env_level;

  // frequency check and level follow the registers they derive from
  assign sweep_change = tone_period_q >> sweep_shift_q;
  assign sweep_target = {1'b0, tone_period_q} + {1'b0, sweep_change} +
                        ((sweep_shift_q == 3'd0) ? 12'd0 : 12'd0);
  assign freq_valid   = (tone_period_q >= 11'd8) && (sweep_down_q || !sweep_target[11]);
  assign env_level    = const_volume_q ? volume_period_q : decay_level_q;

  always_comb begin
    duty_mode_d     = duty_mode_q;
    halt_flag_d     = halt_flag_q;
    const_volume_d  = const_volume_q;
    volume_period_d = volume_period_q;
    sweep_on_d      = sweep_on_q;
    sweep_period_d  = sweep_period_q;
    sweep_down_d    = sweep_down_q;
    sweep_shift_d   = sweep_shift_q;
    tone_period_d   = tone_period_q;
    period_count_d  = period_count_q;
    seq_step_d      = seq_step_q;
    length_enable_d = length_enable_q;
    length_count_d  = length_count_q;
    env_start_d     = env_start_q;
    env_divider_d   = env_divider_q;
    decay_level_d   = decay_level_q;
    sweep_count_d   = sweep_count_q;
    sweep_reload_d  = sweep_reload_q;
    skip_load_d     = skip_load_q;
    sample_hold_d   = sample_hold_q;
    if (step_i) begin
      case (item_i.cmd)
        CmdTimer: begin
          if (period_count_q <= 12'd1) begin
            period_count_d = {1'b0, tone_period_q} + 12'd1;
            seq_step_d     = seq_step_q + 3'd1;
            if ((length_count_q != 8'd0) && freq_valid) begin
              sample_hold_d = DutyTable[duty_mode_q][seq_step_d] ? env_level : 4'd0;
            end else begin
              sample_hold_d = 4'd0;
            end
          end else begin
            period_count_d = period_count_q - 12'd1;
          end
        end
        CmdQuarter: begin
          if (env_start_q) begin
            env_start_d   = 1'b0;
            decay_level_d = 4'd15;
            env_divider_d = {1'b0, volume_period_q} + 5'd1;
          end else if (env_divider_q != 5'd0) begin
            env_divider_d = env_divider_q - 5'd1;
          end else begin
            env_divider_d = {1'b0, volume_period_q} + 5'd1;
            if (decay_level_q != 4'd0) begin
              decay_level_d = decay_level_q - 4'd1;
            end else if (halt_flag_q) begin
              decay_level_d = 4'd15;
            end
          end
        end
        CmdHalf: begin
          if ((length_count_q != 8'd0) && !halt_flag_q) begin
            length_count_d = length_count_q - 8'd1;
            if (item_i.late_length_write) begin
              skip_load_d = 1'b1;
            end
          end
          if (sweep_count_q == 5'd1) begin
            sweep_count_d = {2'b00, sweep_period_q} + 5'd1;
            if (sweep_on_q && (sweep_shift_q != 3'd0) && freq_valid) begin
              if (sweep_down_q) begin
                tone_period_d = tone_period_q - sweep_change;
              end else begin
                tone_period_d = tone_period_q + sweep_change;
              end
            end
          end else begin
            if ((sweep_count_q >= 5'd2) && (sweep_count_q < 5'd16)) begin
              sweep_count_d = sweep_count_q - 5'd1;
            end else begin
              sweep_count_d = SweepIdle;
            end
            if (sweep_reload_q) begin
              sweep_count_d  = {2'b00, sweep_period_q} + 5'd1;
              sweep_reload_d = 1'b0;
            end
          end
        end
        CmdWrite: begin
          case (item_i.reg_sel)
            RegDuty: begin
              duty_mode_d     = item_i.data[7:6];
              halt_flag_d     = item_i.data[5];
              const_volume_d  = item_i.data[4];
              volume_period_d = item_i.data[3:0];
            end
            RegSweep: begin
              sweep_on_d     = item_i.data[7];
              sweep_period_d = item_i.data[6:4];
              sweep_down_d   = item_i.data[3];
              sweep_shift_d  = item_i.data[2:0];
              sweep_reload_d = 1'b1;
            end
            RegPeriodLo: begin
              tone_period_d = {tone_period_q[10:8], item_i.data};
            end
            RegPeriodHi: begin
              tone_period_d = {item_i.data[2:0], tone_period_q[7:0]};
              if (length_enable_q && !skip_load_q) begin
                length_count_d = LengthTable[item_i.data[7:3]];
              end
              skip_load_d = 1'b0;
              seq_step_d  = 3'd0;
              env_start_d = 1'b1;
            end
            RegEnable: begin
              length_enable_d = item_i.data[1];
              if (!item_i.data[1]) begin
                length_count_d = 8'd0;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_mode_q     <= '0;
      halt_flag_q     <= 1'b0;
      const_volume_q  <= 1'b0;
      volume_period_q <= '0;
      sweep_on_q      <= 1'b0;
      sweep_period_q  <= '0;
      sweep_down_q    <= 1'b0;
      sweep_shift_q   <= '0;
      tone_period_q   <= '0;
      period_count_q  <= '0;
      seq_step_q      <= '0;
      length_enable_q <= 1'b0;
      length_count_q  <= '0;
      env_start_q     <= 1'b0;
      env_divider_q   <= '0;
      decay_level_q   <= '0;
      sweep_count_q   <= '0;
      sweep_reload_q  <= 1'b0;
      skip_load_q     <= 1'b0;
      sample_hold_q   <= '0;
    end else begin
      duty_mode_q     <= duty_mode_d;
      halt_flag_q     <= halt_flag_d;
      const_volume_q  <= const_volume_d;
      volume_period_q <= volume_period_d;
      sweep_on_q      <= sweep_on_d;
      sweep_period_q  <= sweep_period_d;
      sweep_down_q    <= sweep_down_d;
      sweep_shift_q   <= sweep_shift_d;
      tone_period_q   <= tone_period_d;
      period_count_q  <= period_count_d;
      seq_step_q      <= seq_step_d;
      length_enable_q <= length_enable_d;
      length_count_q  <= length_count_d;
      env_start_q     <= env_start_d;
      env_divider_q   <= env_divider_d;
      decay_level_q   <= decay_level_d;
      sweep_count_q   <= sweep_count_d;
      sweep_reload_q  <= sweep_reload_d;
      skip_load_q     <= skip_load_d;
      sample_hold_q   <= sample_hold_d;
    end
  end

  assign result_o.sample        = sample_hold_d;
  assign result_o.length_active = (length_count_d != 8'd0);

  `PWC_ASSERT(a_length_off_empty, !length_enable_q |-> (length_count_q == 8'd0))
  `PWC_ASSERT(a_sweep_count_range, (sweep_count_q <= 5'd8) || (sweep_count_q == SweepIdle))
  `PWC_ASSERT(a_env_divider_range, env_divider_q <= 5'd16)

endmodule
